// ===== src/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// Cyclic sort engine package
// Shared default sizes for the cyclic sort engine and its parts.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int CSE_MAX_ITEMS   = 64;
  localparam int CSE_VALUE_WIDTH = 16;

endpackage

// ===== src/cse_stream_if.sv =====
// ----------------------------------------------------------------------------
// Cyclic sort engine channels
// Valid/ready channels for the input values and for the sorted results.
// ----------------------------------------------------------------------------
interface cse_in_if
  import cse_pkg::*;
#(
  parameter int VALUE_WIDTH = CSE_VALUE_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface cse_out_if
  import cse_pkg::*;
#(
  parameter int VALUE_WIDTH = CSE_VALUE_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] sorted_value;
  logic                          last_out;
  logic                          overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

// ===== src/cyclic_sort_engine.sv =====
// ----------------------------------------------------------------------------
// Cyclic sort engine
// Collects a set of signed values, cyclic sorts them in a RAM and emits them.
// ----------------------------------------------------------------------------
// Values arrive as requests on in_s; the request with last set closes the set.
// Each value is written to the next free RAM entry, and in_s.ready stays high
// while the set is being collected. Values beyond MAX_ITEMS are dropped and
// every result of that set then carries overflow.
// On the closing request the engine stops accepting and sorts the n held
// entries through the single RAM port pair: at each position it reads the
// entry and, if its value lies in 1..n, the target entry; it swaps the two
// when they differ and advances otherwise. The results follow on out_m, one
// per entry in position order, with last_out on the final one.
// A stalled receiver holds the result register and the engine waits with it.
// After the final result is taken the engine is ready for the next set.
// A synchronous reset (rst_n low) empties the set and drops any pending
// result; the RAM contents are not cleared.
// ----------------------------------------------------------------------------
module cyclic_sort_engine
  import cse_pkg::*;
#(
  parameter int MAX_ITEMS   = CSE_MAX_ITEMS,
  parameter int VALUE_WIDTH = CSE_VALUE_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  cse_in_if.sink     in_s,
  cse_out_if.source  out_m
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int XW = ((VALUE_WIDTH > CW) ? VALUE_WIDTH : CW) + 1;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_CUR,
    S_GET_CUR,
    S_CHECK,
    S_GET_TGT,
    S_WR_TGT,
    S_EM_RD,
    S_EM_LOAD,
    S_EM_HOLD
  } state_t;

  state_t                        state_r,     state_nxt;
  logic [CW-1:0]                 count_r,     count_nxt;
  logic [CW-1:0]                 pos_r,       pos_nxt;
  logic                          dropped_r,   dropped_nxt;
  logic signed [VALUE_WIDTH-1:0] cur_r,       cur_nxt;
  logic signed [VALUE_WIDTH-1:0] tval_r,      tval_nxt;
  logic [AW-1:0]                 tgt_r,       tgt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic signed [VALUE_WIDTH-1:0] out_val_r,   out_val_nxt;
  logic                          out_last_r,  out_last_nxt;
  logic                          out_ovf_r,   out_ovf_nxt;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [VALUE_WIDTH-1:0] ram_rdata;

  logic signed [XW-1:0] cur_x;
  logic signed [XW-1:0] n_x;
  logic [XW-1:0]        tgt_sum;
  logic                 in_range;
  logic [CW-1:0]        pos_inc;
  logic                 has_room;

  assign cur_x    = XW'(cur_r);
  assign n_x      = $signed({1'b0, (XW-1)'(count_r)});
  assign tgt_sum  = cur_x - XW'(1);
  assign in_range = !cur_x[XW-1] && (cur_x != '0) && (cur_x <= n_x);
  assign pos_inc  = pos_r + CW'(1);
  assign has_room = count_r < CW'(MAX_ITEMS);

  cse_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    dropped_nxt   = dropped_r;
    cur_nxt       = cur_r;
    tval_nxt      = tval_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = out_valid_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    ram_we        = 1'b0;
    ram_waddr     = count_r[AW-1:0];
    ram_wdata     = in_s.value;
    ram_raddr     = pos_r[AW-1:0];

    unique case (state_r)
      S_LOAD: begin
        if (in_s.valid) begin
          if (has_room) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_s.last) begin
            pos_nxt   = '0;
            state_nxt = S_RD_CUR;
          end
        end
      end
      S_RD_CUR: begin
        state_nxt = S_GET_CUR;
      end
      S_GET_CUR: begin
        cur_nxt   = $signed(ram_rdata);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        tgt_nxt   = tgt_sum[AW-1:0];
        ram_raddr = tgt_sum[AW-1:0];
        if (in_range) begin
          state_nxt = S_GET_TGT;
        end else if (pos_inc == count_r) begin
          pos_nxt   = '0;
          state_nxt = S_EM_RD;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = S_RD_CUR;
        end
      end
      S_GET_TGT: begin
        tval_nxt = $signed(ram_rdata);
        if ($signed(ram_rdata) != cur_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[AW-1:0];
          ram_wdata = ram_rdata;
          state_nxt = S_WR_TGT;
        end else if (pos_inc == count_r) begin
          pos_nxt   = '0;
          state_nxt = S_EM_RD;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = S_RD_CUR;
        end
      end
      S_WR_TGT: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        ram_wdata = cur_r;
        cur_nxt   = tval_r;
        state_nxt = S_CHECK;
      end
      S_EM_RD: begin
        state_nxt = S_EM_LOAD;
      end
      S_EM_LOAD: begin
        out_val_nxt   = $signed(ram_rdata);
        out_last_nxt  = (pos_inc == count_r);
        out_ovf_nxt   = dropped_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EM_HOLD;
      end
      S_EM_HOLD: begin
        if (out_m.ready) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            count_nxt   = '0;
            pos_nxt     = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            pos_nxt   = pos_inc;
            state_nxt = S_EM_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      pos_r       <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    tval_r     <= tval_nxt;
    tgt_r      <= tgt_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign in_s.ready         = (state_r == S_LOAD);
  assign out_m.valid        = out_valid_r;
  assign out_m.sorted_value = out_val_r;
  assign out_m.last_out     = out_last_r;
  assign out_m.overflow     = out_ovf_r;

endmodule

// ===== src/cse_ram.sv =====
// ----------------------------------------------------------------------------
// Cyclic sort engine RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cse_ram
  import cse_pkg::*;
#(
  parameter int WIDTH = CSE_VALUE_WIDTH,
  parameter int DEPTH = CSE_MAX_ITEMS,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cse_checker.sv =====
// ----------------------------------------------------------------------------
// Cyclic sort engine checker
// Port-level assertions on the cyclic sort engine, bound to the top level.
// ----------------------------------------------------------------------------
module cse_checker
  import cse_pkg::*;
#(
  parameter int VALUE_WIDTH = CSE_VALUE_WIDTH
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_sorted_value,
  input logic                   out_last_out,
  input logic                   out_overflow
);

  // The engine never collects a set while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_sorted_value) && $stable(out_last_out) &&
      $stable(out_overflow))
    else $error("stalled result changed");

  // After the final result of a set the engine returns to collecting.
  a_last_returns: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_out |=> in_ready && !out_valid)
    else $error("engine not ready after final result");

  // A new set cannot produce a result in the cycle after a value request.
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result right after a value request");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind cyclic_sort_engine cse_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_cse_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_s.valid),
  .in_ready         (in_s.ready),
  .out_valid        (out_m.valid),
  .out_ready        (out_m.ready),
  .out_sorted_value (out_m.sorted_value),
  .out_last_out     (out_m.last_out),
  .out_overflow     (out_m.overflow)
);

// ===== bench/cyclic_sort_engine_test.sv =====
// ----------------------------------------------------------------------------
// Cyclic sort engine testbench
// Sends sets of signed values to the engine and keeps its own cyclic sort of
// every set. Each result that leaves the engine is compared with the oldest
// predicted one. Both channels idle at random, and one long result stall
// backs the engine up. Sets that overflow the store are also covered.
// ----------------------------------------------------------------------------
module cyclic_sort_engine_test;
  import cse_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW                 = CSE_VALUE_WIDTH;
  localparam int STORE_DEPTH        = CSE_MAX_ITEMS;
  localparam int RESULT_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int TAIL_CYCLES        = 50;
  localparam int RANDOM_ITEMS       = 240;

  typedef logic signed [VW-1:0] value_t;

  typedef struct packed {
    logic signed [VW-1:0] sorted_value;
    logic                 last_out;
    logic                 overflow;
  } sorted_result_t;

  typedef enum int {
    SHAPE_PERMUTATION,
    SHAPE_NEAR_RANGE,
    SHAPE_ANY_VALUE
  } set_shape_e;

  logic clk;
  logic rst_n;

  cse_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  cse_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  cyclic_sort_engine #(
    .MAX_ITEMS  (STORE_DEPTH),
    .VALUE_WIDTH(VW)
  ) u_top (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_ch),
    .out_m(out_ch)
  );

  value_t         held_values [STORE_DEPTH];
  int             held_count;
  bit             held_dropped;
  sorted_result_t sorted_results_due [$];

  int error_count;
  int items_sent;
  int stall_cycles;
  bit tx_idle_enable;
  bit rx_idle_enable;
  bit hold_results_request;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) begin
      return $urandom_range(10, 40);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= 50) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic void cyclic_sort_held(input int n);
    int     pos;
    int     target;
    value_t cur;
    pos = 0;
    while (pos < n) begin
      cur = held_values[pos];
      target = cur - 1;
      if (cur >= 1 && cur <= n && held_values[target] != cur) begin
        held_values[pos]    = held_values[target];
        held_values[target] = cur;
      end else begin
        pos++;
      end
    end
  endfunction

  function automatic void absorb_value(input value_t v, input bit is_last);
    sorted_result_t r;
    if (held_count < STORE_DEPTH) begin
      held_values[held_count] = v;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (is_last) begin
      cyclic_sort_held(held_count);
      for (int k = 0; k < held_count; k++) begin
        r.sorted_value = held_values[k];
        r.last_out     = (k == held_count - 1);
        r.overflow     = held_dropped;
        sorted_results_due.push_back(r);
      end
      held_count   = 0;
      held_dropped = 1'b0;
    end
  endfunction

  task automatic send_value(input value_t v, input bit is_last);
    int gap;
    gap = 0;
    if (tx_idle_enable && $urandom_range(0, 2) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.last  <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_value(v, is_last);
    items_sent++;
  endtask

  task automatic send_set(input value_t vals [$]);
    foreach (vals[i]) begin
      send_value(vals[i], i == vals.size() - 1);
    end
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sorted_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_set(input int n, input set_shape_e shape);
    value_t vals [$];
    value_t t;
    int     j;
    for (int i = 0; i < n; i++) begin
      case (shape)
        SHAPE_PERMUTATION: begin
          vals.push_back(value_t'(i + 1));
        end
        SHAPE_NEAR_RANGE: begin
          vals.push_back(value_t'(int'($urandom_range(0, n + 3)) - 2));
        end
        default: begin
          vals.push_back(value_t'($urandom));
        end
      endcase
    end
    if (shape == SHAPE_PERMUTATION) begin
      for (int i = n - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = vals[i];
        vals[i] = vals[j];
        vals[j] = t;
      end
      if ($urandom_range(0, 2) == 0) begin
        vals[$urandom_range(0, n - 1)] = value_t'($urandom_range(0, n + 1));
      end
    end
    send_set(vals);
  endtask

  task automatic test_single_entry();
    value_t vals [$];
    vals = '{value_t'(1)};
    send_set(vals);
    vals = '{value_t'(-5)};
    send_set(vals);
  endtask

  task automatic test_value_extremes();
    value_t vals [$];
    vals = '{value_t'(32767), value_t'(-32768), value_t'(0), value_t'(-1),
             value_t'(16'h5555), value_t'(16'h2AAA)};
    send_set(vals);
  endtask

  task automatic test_permutation();
    value_t vals [$];
    vals = '{value_t'(3), value_t'(5), value_t'(1), value_t'(4), value_t'(2)};
    send_set(vals);
  endtask

  task automatic test_duplicates_and_out_of_range();
    value_t vals [$];
    vals = '{value_t'(2), value_t'(2), value_t'(6), value_t'(1), value_t'(0),
             value_t'(-3), value_t'(5)};
    send_set(vals);
  endtask

  task automatic test_store_capacity();
    send_random_set(STORE_DEPTH, SHAPE_PERMUTATION);
    send_random_set(STORE_DEPTH + 2, SHAPE_PERMUTATION);
    send_random_set(STORE_DEPTH + 1, SHAPE_ANY_VALUE);
  endtask

  task automatic test_random_sets();
    int         first_item;
    int         n;
    int         pick;
    set_shape_e shape;
    first_item = items_sent;
    while (items_sent - first_item < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        n = $urandom_range(1, 10);
      end else if (pick < 95) begin
        n = $urandom_range(11, 32);
      end else begin
        n = $urandom_range(33, STORE_DEPTH);
      end
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        shape = SHAPE_PERMUTATION;
      end else if (pick < 8) begin
        shape = SHAPE_NEAR_RANGE;
      end else begin
        shape = SHAPE_ANY_VALUE;
      end
      tx_idle_enable = ($urandom_range(0, 4) != 0);
      rx_idle_enable = ($urandom_range(0, 4) != 0);
      send_random_set(n, shape);
    end
    tx_idle_enable = 1'b1;
    rx_idle_enable = 1'b1;
  endtask

  task automatic test_result_backpressure();
    tx_idle_enable       = 1'b0;
    hold_results_request = 1'b1;
    for (int s = 0; s < 4; s++) begin
      send_random_set($urandom_range(6, 12), SHAPE_PERMUTATION);
    end
    tx_idle_enable = 1'b1;
  endtask

  task automatic test_pause_until_drained();
    send_random_set($urandom_range(3, 9), SHAPE_NEAR_RANGE);
    release_input();
    wait_drained();
    send_random_set($urandom_range(3, 9), SHAPE_PERMUTATION);
  endtask

  task automatic settle();
    release_input();
    wait_drained();
  endtask

  initial begin : result_receiver
    int gap;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results_request) begin
        hold_results_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (RESULT_HOLD_CYCLES) @(posedge clk);
      end else if (rx_idle_enable && $urandom_range(0, 3) == 0) begin
        gap = pick_gap();
        out_ch.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    sorted_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sorted_results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, value %0d", out_ch.sorted_value));
      end else begin
        want = sorted_results_due.pop_front();
        if (out_ch.sorted_value !== want.sorted_value) begin
          report_mismatch($sformatf("sorted_value %0d, predicted %0d",
                                    out_ch.sorted_value, want.sorted_value));
        end
        if (out_ch.last_out !== want.last_out) begin
          report_mismatch($sformatf("last_out %b, predicted %b",
                                    out_ch.last_out, want.last_out));
        end
        if (out_ch.overflow !== want.overflow) begin
          report_mismatch($sformatf("overflow %b, predicted %b",
                                    out_ch.overflow, want.overflow));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("[cyclic_sort_engine] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    error_count          = 0;
    items_sent           = 0;
    stall_cycles         = 0;
    held_count           = 0;
    held_dropped         = 1'b0;
    tx_idle_enable       = 1'b1;
    rx_idle_enable       = 1'b1;
    hold_results_request = 1'b0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.last  <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_entry();
    settle();
    test_value_extremes();
    settle();
    test_permutation();
    settle();
    test_duplicates_and_out_of_range();
    settle();
    test_store_capacity();
    settle();
    test_result_backpressure();
    settle();
    test_pause_until_drained();
    settle();
    test_random_sets();
    settle();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && sorted_results_due.size() == 0) begin
      $display("[cyclic_sort_engine] OK");
    end else begin
      $display("[cyclic_sort_engine] ERROR");
    end
    $finish;
  end

endmodule

// ===== cyclic_sort_engine.f =====
src/cse_pkg.sv
src/cse_stream_if.sv
src/cse_ram.sv
src/cyclic_sort_engine.sv
src/cse_checker.sv
bench/cyclic_sort_engine_test.sv
